// ===== hdl/lpct_pkg.sv =====
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types, register map and fixed-point constants for the lidar point
// crop and transform block.
// ----------------------------------------------------------------------------
package lpct_pkg;

  // fixed-point formats
  localparam int COORD_FRAC_BITS = 16;
  localparam int TRIG_FRAC_BITS  = 14;

  // coordinate width once the left-sensor offset has been applied
  localparam int COORD_XW = 33;

  // decimal constant in metres (scaled by 1e5) to coordinate format, ties up
  localparam longint CROP_X_OFS = ((longint'(13388) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint CROP_Y_OFS = ((longint'(11369) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint CROP_R     = ((longint'(35000) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint CROP_R_SQ  = CROP_R * CROP_R;
  localparam longint LEFT_X_OFS = ((longint'(2843) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint LEFT_Y_OFS = ((longint'(14337) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint LEFT_Z_OFS = ((longint'(35000) << COORD_FRAC_BITS) + 50000) / 100000;

  // half an lsb of the trig scale, added before the rounding shift
  localparam longint RND_BIAS = longint'(1) << (TRIG_FRAC_BITS - 1);

  // queue between the classifier and the transform pipeline
  localparam int QUEUE_DEPTH = 4;

  // register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROLL_COS_SIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_COS_SIN   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_COS_SIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X         = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z         = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ONE_SENSOR_MODE = 3'd6;

  // input point
  typedef struct packed {
    logic               from_left;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               scan_end;
  } in_item_t;

  // transformed point
  typedef struct packed {
    logic               kept;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               scan_end_out;
  } out_item_t;

  // classified point, offset already applied
  typedef struct packed {
    logic                       kept;
    logic signed [COORD_XW-1:0] x;
    logic signed [COORD_XW-1:0] y;
    logic signed [COORD_XW-1:0] z;
    logic                       scan_end;
  } cls_item_t;

  // configuration register file contents
  typedef struct packed {
    logic [31:0]        roll_cos_sin;
    logic [31:0]        pitch_cos_sin;
    logic [31:0]        yaw_cos_sin;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic               one_sensor_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    roll_cos_sin:    32'h4000_0000,
    pitch_cos_sin:   32'h4000_0000,
    yaw_cos_sin:     32'h4000_0000,
    shift_x:         32'sd0,
    shift_y:         32'sd0,
    shift_z:         32'sd0,
    one_sensor_mode: 1'b0
  };

endpackage

// ===== hdl/lidar_point_crop_and_transform.sv =====
// ----------------------------------------------------------------------------
// lidar_point_crop_and_transform
// Crops points near the sensor mount, applies the left-sensor offset, then
// rotates (roll, pitch, yaw) and translates each point.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------
//   in       | in_valid_i / in_ready_o     | in_data_i  (in_item_t)
//   out      | out_valid_o / out_ready_i   | out_data_o (out_item_t)
//   config   | psel, penable, pwrite       | paddr, pwdata, prdata
//
// one point per cycle sustained while out_ready_i is held high; each request gives exactly one result
// six register stages: classify, queue, roll, pitch, yaw and output
// a four-entry queue lets the classifier keep taking requests while the
// output is stalled; in_ready_o drops only when that queue is full
// reset is asynchronous and active low, no clearing pass is needed
// ----------------------------------------------------------------------------
module lidar_point_crop_and_transform (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lpct_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lpct_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpct_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lpct_pkg::*;

  cfg_t      cfg;
  logic      f2q_valid, f2q_ready, q2b_valid, q2b_ready;
  cls_item_t f2q_data, q2b_data;

  // configuration registers
  lpct_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classifier
  lpct_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .one_sensor_mode_i (cfg.one_sensor_mode),
    .cls_valid_o       (f2q_valid),
    .cls_ready_i       (f2q_ready),
    .cls_data_o        (f2q_data)
  );

  // decoupling queue
  lpct_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f2q_valid),
    .push_ready_o (f2q_ready),
    .push_data_i  (f2q_data),
    .pop_valid_o  (q2b_valid),
    .pop_ready_i  (q2b_ready),
    .pop_data_o   (q2b_data)
  );

  // transform pipeline
  lpct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cls_valid_i (q2b_valid),
    .cls_ready_o (q2b_ready),
    .cls_data_i  (q2b_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/lpct_regs.sv =====
// ----------------------------------------------------------------------------
// lpct_regs
// APB-style configuration registers: trig pairs, translation and mode.
// ----------------------------------------------------------------------------
module lpct_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpct_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lpct_pkg::cfg_t              cfg_o
);
  import lpct_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ROLL_COS_SIN:    cfg_d.roll_cos_sin    = pwdata;
        REG_PITCH_COS_SIN:   cfg_d.pitch_cos_sin   = pwdata;
        REG_YAW_COS_SIN:     cfg_d.yaw_cos_sin     = pwdata;
        REG_SHIFT_X:         cfg_d.shift_x         = $signed(pwdata);
        REG_SHIFT_Y:         cfg_d.shift_y         = $signed(pwdata);
        REG_SHIFT_Z:         cfg_d.shift_z         = $signed(pwdata);
        REG_ONE_SENSOR_MODE: cfg_d.one_sensor_mode = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ROLL_COS_SIN:    prdata = cfg_q.roll_cos_sin;
      REG_PITCH_COS_SIN:   prdata = cfg_q.pitch_cos_sin;
      REG_YAW_COS_SIN:     prdata = cfg_q.yaw_cos_sin;
      REG_SHIFT_X:         prdata = cfg_q.shift_x;
      REG_SHIFT_Y:         prdata = cfg_q.shift_y;
      REG_SHIFT_Z:         prdata = cfg_q.shift_z;
      REG_ONE_SENSOR_MODE: prdata = {31'd0, cfg_q.one_sensor_mode};
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/lpct_front.sv =====
// ----------------------------------------------------------------------------
// lpct_front
// Accepts points, runs the radius crop and mode test, applies the
// left-sensor offset and hands classified points to the queue.
// ----------------------------------------------------------------------------
module lpct_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lpct_pkg::in_item_t   in_data_i,
  input  logic                 one_sensor_mode_i,
  output logic                 cls_valid_o,
  input  logic                 cls_ready_i,
  output lpct_pkg::cls_item_t  cls_data_o
);
  import lpct_pkg::*;

  logic signed [COORD_XW-1:0] dx, dy;
  logic [31:0]                adx, ady;
  logic [63:0]                sqx_d, sqx_q, sqy_d, sqy_q;
  in_item_t                   item_q, item_d;
  logic                       vld_q, vld_d;
  logic [64:0]                dist_sq;
  logic                       keep;
  logic signed [COORD_XW-1:0] ofs_x, ofs_y, ofs_z;

  // offset from the crop centre, magnitude and square
  assign dx  = COORD_XW'($signed(in_data_i.px)) + COORD_XW'(CROP_X_OFS);
  assign dy  = COORD_XW'($signed(in_data_i.py)) + COORD_XW'(CROP_Y_OFS);
  assign adx = dx[COORD_XW-1] ? 32'(-dx) : 32'(dx);
  assign ady = dy[COORD_XW-1] ? 32'(-dy) : 32'(dy);

  assign in_ready_o = ~vld_q | cls_ready_i;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    sqx_d  = sqx_q;
    sqy_d  = sqy_q;
    if (in_ready_o) begin
      vld_d  = in_valid_i;
      item_d = in_data_i;
      sqx_d  = {32'd0, adx} * {32'd0, adx};
      sqy_d  = {32'd0, ady} * {32'd0, ady};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
  end

  // crop and mode decision
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign keep    = (dist_sq >= 65'(CROP_R_SQ)) & ~(item_q.from_left & one_sensor_mode_i);

  // left sensor mount offset
  assign ofs_x = item_q.from_left ? COORD_XW'(LEFT_X_OFS) : '0;
  assign ofs_y = item_q.from_left ? COORD_XW'(LEFT_Y_OFS) : '0;
  assign ofs_z = item_q.from_left ? COORD_XW'(LEFT_Z_OFS) : '0;

  assign cls_valid_o         = vld_q;
  assign cls_data_o.kept     = keep;
  assign cls_data_o.x        = COORD_XW'($signed(item_q.px)) + ofs_x;
  assign cls_data_o.y        = COORD_XW'($signed(item_q.py)) - ofs_y;
  assign cls_data_o.z        = COORD_XW'($signed(item_q.pz)) + ofs_z;
  assign cls_data_o.scan_end = item_q.scan_end;

endmodule

// ===== hdl/lpct_queue.sv =====
// ----------------------------------------------------------------------------
// lpct_queue
// Short register queue between the classifier and the transform pipeline.
// ----------------------------------------------------------------------------
module lpct_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  lpct_pkg::cls_item_t  push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output lpct_pkg::cls_item_t  pop_data_o
);
  import lpct_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push & ~pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop & ~push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/lpct_back.sv =====
// ----------------------------------------------------------------------------
// lpct_back
// Roll, pitch and yaw rotation stages, translation, saturation and the
// output register.
// ----------------------------------------------------------------------------
module lpct_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpct_pkg::cfg_t       cfg_i,
  input  logic                 cls_valid_i,
  output logic                 cls_ready_o,
  input  lpct_pkg::cls_item_t  cls_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lpct_pkg::out_item_t  out_data_o
);
  import lpct_pkg::*;

  // stage widths: product, sum, rounded result
  localparam int P1W = COORD_XW + 16;
  localparam int S1W = P1W + 1;
  localparam int RW1 = S1W + 1 - TRIG_FRAC_BITS;
  localparam int P2W = RW1 + 16;
  localparam int S2W = P2W + 1;
  localparam int RW2 = S2W + 1 - TRIG_FRAC_BITS;
  localparam int P3W = RW2 + 16;
  localparam int S3W = P3W + 1;
  localparam int RW3 = S3W + 1 - TRIG_FRAC_BITS;
  localparam int OW  = RW3 + 1;

  function automatic logic [31:0] sat32(input logic signed [OW-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[OW-1:31];
    all_zero = ~|v[OW-1:31];
    if (all_one | all_zero) begin
      sat32 = v[31:0];
    end else if (v[OW-1]) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = 32'h7fff_ffff;
    end
  endfunction

  logic signed [15:0] cr, sr, cp, sp, cy, sy;

  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d, v4_q, v4_d;
  logic en1, en2, en3, en4;

  logic                       kept1_q, kept1_d, end1_q, end1_d;
  logic signed [COORD_XW-1:0] x1_q, x1_d;
  logic signed [RW1-1:0]      ry1_q, ry1_d, rz1_q, rz1_d;

  logic                       kept2_q, kept2_d, end2_q, end2_d;
  logic signed [RW1-1:0]      ry2_q, ry2_d;
  logic signed [RW2-1:0]      ax2_q, ax2_d, az2_q, az2_d;

  logic                       kept3_q, kept3_d, end3_q, end3_d;
  logic signed [OW-1:0]       ox3_q, ox3_d, oy3_q, oy3_d, oz3_q, oz3_d;

  out_item_t                  out_q, out_d;

  logic signed [COORD_XW-1:0] y0, z0;
  logic signed [P1W-1:0]      p_ycr, p_zsr, p_ysr, p_zcr;
  logic signed [S1W-1:0]      s_ry, s_rz;
  logic signed [S1W:0]        t_ry, t_rz;
  logic signed [P2W-1:0]      p_xcp, p_rzsp, p_rzcp, p_xsp;
  logic signed [S2W-1:0]      s_ax, s_az;
  logic signed [S2W:0]        t_ax, t_az;
  logic signed [P3W-1:0]      p_axcy, p_rysy, p_axsy, p_rycy;
  logic signed [S3W-1:0]      s_ox, s_oy;
  logic signed [S3W:0]        t_ox, t_oy;
  logic signed [RW3-1:0]      r_ox, r_oy;

  assign cr = $signed(cfg_i.roll_cos_sin[31:16]);
  assign sr = $signed(cfg_i.roll_cos_sin[15:0]);
  assign cp = $signed(cfg_i.pitch_cos_sin[31:16]);
  assign sp = $signed(cfg_i.pitch_cos_sin[15:0]);
  assign cy = $signed(cfg_i.yaw_cos_sin[31:16]);
  assign sy = $signed(cfg_i.yaw_cos_sin[15:0]);

  // stall chain, the output register drives it
  assign en4         = ~v4_q | out_ready_i;
  assign en3         = ~v3_q | en4;
  assign en2         = ~v2_q | en3;
  assign en1         = ~v1_q | en2;
  assign cls_ready_o = en1;

  // roll about x
  assign y0    = cls_data_i.y;
  assign z0    = cls_data_i.z;
  assign p_ycr = P1W'(y0) * P1W'(cr);
  assign p_zsr = P1W'(z0) * P1W'(sr);
  assign p_ysr = P1W'(y0) * P1W'(sr);
  assign p_zcr = P1W'(z0) * P1W'(cr);
  assign s_ry  = S1W'(p_ycr) - S1W'(p_zsr);
  assign s_rz  = S1W'(p_ysr) + S1W'(p_zcr);
  assign t_ry  = (S1W+1)'(s_ry) + (S1W+1)'(RND_BIAS);
  assign t_rz  = (S1W+1)'(s_rz) + (S1W+1)'(RND_BIAS);

  // pitch about y
  assign p_xcp  = P2W'(x1_q) * P2W'(cp);
  assign p_rzsp = P2W'(rz1_q) * P2W'(sp);
  assign p_rzcp = P2W'(rz1_q) * P2W'(cp);
  assign p_xsp  = P2W'(x1_q) * P2W'(sp);
  assign s_ax   = S2W'(p_xcp) + S2W'(p_rzsp);
  assign s_az   = S2W'(p_rzcp) - S2W'(p_xsp);
  assign t_ax   = (S2W+1)'(s_ax) + (S2W+1)'(RND_BIAS);
  assign t_az   = (S2W+1)'(s_az) + (S2W+1)'(RND_BIAS);

  // yaw about z and translation
  assign p_axcy = P3W'(ax2_q) * P3W'(cy);
  assign p_rysy = P3W'(ry2_q) * P3W'(sy);
  assign p_axsy = P3W'(ax2_q) * P3W'(sy);
  assign p_rycy = P3W'(ry2_q) * P3W'(cy);
  assign s_ox   = S3W'(p_axcy) - S3W'(p_rysy);
  assign s_oy   = S3W'(p_axsy) + S3W'(p_rycy);
  assign t_ox   = (S3W+1)'(s_ox) + (S3W+1)'(RND_BIAS);
  assign t_oy   = (S3W+1)'(s_oy) + (S3W+1)'(RND_BIAS);
  assign r_ox   = RW3'(t_ox >>> TRIG_FRAC_BITS);
  assign r_oy   = RW3'(t_oy >>> TRIG_FRAC_BITS);

  // next-state for all stages
  always_comb begin
    v1_d = v1_q; kept1_d = kept1_q; end1_d = end1_q;
    x1_d = x1_q; ry1_d = ry1_q; rz1_d = rz1_q;
    v2_d = v2_q; kept2_d = kept2_q; end2_d = end2_q;
    ry2_d = ry2_q; ax2_d = ax2_q; az2_d = az2_q;
    v3_d = v3_q; kept3_d = kept3_q; end3_d = end3_q;
    ox3_d = ox3_q; oy3_d = oy3_q; oz3_d = oz3_q;
    v4_d = v4_q; out_d = out_q;
    if (en1) begin
      v1_d    = cls_valid_i;
      kept1_d = cls_data_i.kept;
      end1_d  = cls_data_i.scan_end;
      x1_d    = cls_data_i.x;
      ry1_d   = RW1'(t_ry >>> TRIG_FRAC_BITS);
      rz1_d   = RW1'(t_rz >>> TRIG_FRAC_BITS);
    end
    if (en2) begin
      v2_d    = v1_q;
      kept2_d = kept1_q;
      end2_d  = end1_q;
      ry2_d   = ry1_q;
      ax2_d   = RW2'(t_ax >>> TRIG_FRAC_BITS);
      az2_d   = RW2'(t_az >>> TRIG_FRAC_BITS);
    end
    if (en3) begin
      v3_d    = v2_q;
      kept3_d = kept2_q;
      end3_d  = end2_q;
      ox3_d   = OW'(r_ox) + OW'(cfg_i.shift_x);
      oy3_d   = OW'(r_oy) + OW'(cfg_i.shift_y);
      oz3_d   = OW'(az2_q) + OW'(cfg_i.shift_z);
    end
    if (en4) begin
      v4_d               = v3_q;
      out_d.kept         = kept3_q;
      out_d.scan_end_out = end3_q;
      out_d.qx           = kept3_q ? $signed(sat32(ox3_q)) : 32'sd0;
      out_d.qy           = kept3_q ? $signed(sat32(oy3_q)) : 32'sd0;
      out_d.qz           = kept3_q ? $signed(sat32(oz3_q)) : 32'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kept1_q <= kept1_d;
    end1_q  <= end1_d;
    x1_q    <= x1_d;
    ry1_q   <= ry1_d;
    rz1_q   <= rz1_d;
    kept2_q <= kept2_d;
    end2_q  <= end2_d;
    ry2_q   <= ry2_d;
    ax2_q   <= ax2_d;
    az2_q   <= az2_d;
    kept3_q <= kept3_d;
    end3_q  <= end3_d;
    ox3_q   <= ox3_d;
    oy3_q   <= oy3_d;
    oz3_q   <= oz3_d;
    out_q   <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/lpct_checker.sv =====
// ----------------------------------------------------------------------------
// lpct_checker
// Port-level checks for the lidar point crop and transform block.
// ----------------------------------------------------------------------------
module lpct_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input lpct_pkg::out_item_t         out_data_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [lpct_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);
  import lpct_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a dropped point carries zero coordinates
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kept |->
      out_data_o.qx == 32'sd0 && out_data_o.qy == 32'sd0 && out_data_o.qz == 32'sd0)
    else $error("dropped point with non-zero coordinates");

  // input back-pressure only follows a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // a full-width register reads back what was just written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && !pwrite && $past(rst_ni) &&
    $past(psel && penable && pwrite) && paddr == $past(paddr) &&
    paddr[ADDR_W-1:2] < REG_ONE_SENSOR_MODE |-> prdata == $past(pwdata))
    else $error("register read-back mismatch");

endmodule

bind lidar_point_crop_and_transform lpct_checker u_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar point crop and transform block. A queue
// of points feeds a valid/ready driver. Each accepted request is predicted
// with the current register set. A monitor checks every result in order
// against those predictions. Registers are written over the APB port and
// read back between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
  import lpct_pkg::*;

  typedef longint unsigned u64_t;

  localparam int  ITEMS_PER_PHASE = 215;
  localparam int  NUM_PHASES      = 8;
  localparam int  SETTLE_CYCLES   = 20;
  localparam int  CYCLE_LIMIT     = 200000;
  localparam int  IDLE_PERCENT    = 22;

  // mount geometry in coordinate format, ties rounded up
  localparam longint MOUNT_X_OFS = ((longint'(13388) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint MOUNT_Y_OFS = ((longint'(11369) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint CROP_RADIUS = ((longint'(35000) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint LEFT_DX     = ((longint'(2843) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint LEFT_DY     = ((longint'(14337) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint LEFT_DZ     = ((longint'(35000) << COORD_FRAC_BITS) + 50000) / 100000;
  localparam longint TRIG_HALF   = longint'(1) << (TRIG_FRAC_BITS - 1);
  localparam longint SAT_MAX     = 64'sd2147483647;
  localparam longint SAT_MIN     = -64'sd2147483648;

  localparam logic [31:0] TRIG_IDENTITY = 32'h4000_0000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  in_item_t  pending_pts[$];
  out_item_t expected_pts[$];
  cfg_t      active_cfg;
  cfg_t      next_cfg;
  out_item_t want_pt;
  int        n_errors    = 0;
  int        n_sent      = 0;
  int        n_recv      = 0;
  int        cycle_count = 0;

  lidar_point_crop_and_transform i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // divide by the trig scale, nearest with ties upward
  function automatic longint trig_round(input longint v);
    return (v + TRIG_HALF) >>> TRIG_FRAC_BITS;
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > SAT_MAX) return 32'h7FFF_FFFF;
    if (v < SAT_MIN) return 32'h8000_0000;
    return 32'(v);
  endfunction

  // crop test, left offset, roll/pitch/yaw rotation and translation
  function automatic out_item_t predict_point(input in_item_t p, input cfg_t c);
    longint    x, y, z, dx, dy, ry, rz, ax, az;
    longint    cos_r, sin_r, cos_p, sin_p, cos_w, sin_w;
    u64_t      dist_sq;
    logic      keep;
    out_item_t r;
    x = longint'($signed(p.px));
    y = longint'($signed(p.py));
    z = longint'($signed(p.pz));
    dx = x + MOUNT_X_OFS;
    dy = y + MOUNT_Y_OFS;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    dist_sq = u64_t'(dx) * u64_t'(dx) + u64_t'(dy) * u64_t'(dy);
    keep = (dist_sq >= u64_t'(CROP_RADIUS * CROP_RADIUS));
    if (p.from_left && c.one_sensor_mode) keep = 1'b0;
    r = '0;
    r.kept = keep;
    r.scan_end_out = p.scan_end;
    if (keep) begin
      if (p.from_left) begin
        x = x + LEFT_DX;
        y = y - LEFT_DY;
        z = z + LEFT_DZ;
      end
      cos_r = longint'($signed(c.roll_cos_sin[31:16]));
      sin_r = longint'($signed(c.roll_cos_sin[15:0]));
      cos_p = longint'($signed(c.pitch_cos_sin[31:16]));
      sin_p = longint'($signed(c.pitch_cos_sin[15:0]));
      cos_w = longint'($signed(c.yaw_cos_sin[31:16]));
      sin_w = longint'($signed(c.yaw_cos_sin[15:0]));
      ry = trig_round(y * cos_r - z * sin_r);
      rz = trig_round(y * sin_r + z * cos_r);
      ax = trig_round(x * cos_p + rz * sin_p);
      az = trig_round(rz * cos_p - x * sin_p);
      r.qx = sat32(trig_round(ax * cos_w - ry * sin_w) + longint'($signed(c.shift_x)));
      r.qy = sat32(trig_round(ax * sin_w + ry * cos_w) + longint'($signed(c.shift_y)));
      r.qz = sat32(az + longint'($signed(c.shift_z)));
    end
    return r;
  endfunction

  function automatic in_item_t make_point(input logic left, input longint x,
                                          input longint y, input longint z,
                                          input logic last);
    in_item_t p;
    p.from_left = left;
    p.px = 32'(x);
    p.py = 32'(y);
    p.pz = 32'(z);
    p.scan_end = last;
    return p;
  endfunction

  // mostly plausible points, some around the crop circle, some full range
  function automatic in_item_t rand_point();
    in_item_t    p;
    int unsigned sel;
    longint      span;
    sel = $urandom_range(9);
    span = CROP_RADIUS + 2000;
    p.from_left = 1'($urandom_range(1));
    p.scan_end = ($urandom_range(15) == 0);
    case (sel)
      0, 1: begin
        p.px = $urandom;
        p.py = $urandom;
        p.pz = $urandom;
      end
      2, 3: begin
        p.px = 32'(-MOUNT_X_OFS + longint'($urandom_range(2 * span)) - span);
        p.py = 32'(-MOUNT_Y_OFS + longint'($urandom_range(2 * span)) - span);
        p.pz = 32'(longint'($urandom_range(1 << 22)) - (1 << 21));
      end
      default: begin
        p.px = 32'(longint'($urandom_range(1 << 23)) - (1 << 22));
        p.py = 32'(longint'($urandom_range(1 << 23)) - (1 << 22));
        p.pz = 32'(longint'($urandom_range(1 << 23)) - (1 << 22));
      end
    endcase
    return p;
  endfunction

  // cosine and sine each within [-1, 1]
  function automatic logic [31:0] rand_cos_sin();
    return {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384)};
  endfunction

  function automatic logic [31:0] rand_shift();
    return 32'($urandom_range(1 << 23) - (1 << 22));
  endfunction

  // append one point to the pending requests
  task automatic queue_point(input in_item_t p);
    pending_pts = {pending_pts, p};
  endtask

  // corners, crop boundary and plain points on both sensors
  task automatic push_directed();
    queue_point(make_point(1'b0, 0, 0, 0, 1'b0));
    queue_point(make_point(1'b1, 0, 0, 0, 1'b1));
    queue_point(make_point(1'b0, CROP_RADIUS - MOUNT_X_OFS, -MOUNT_Y_OFS, 0, 1'b0));
    queue_point(make_point(1'b0, CROP_RADIUS - 1 - MOUNT_X_OFS, -MOUNT_Y_OFS,
                           0, 1'b0));
    queue_point(make_point(1'b1, -MOUNT_X_OFS, CROP_RADIUS - MOUNT_Y_OFS,
                           65536, 1'b0));
    queue_point(make_point(1'b1, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1));
    queue_point(make_point(1'b0, SAT_MIN, SAT_MIN, SAT_MIN, 1'b0));
    queue_point(make_point(1'b1, SAT_MIN, SAT_MAX, SAT_MIN, 1'b1));
    queue_point(make_point(1'b0, SAT_MAX, SAT_MIN, SAT_MAX, 1'b1));
    queue_point(make_point(1'b1, 65536, 131072, 196608, 1'b0));
    queue_point(make_point(1'b0, 65536, 131072, 196608, 1'b1));
    queue_point(make_point(1'b1, SAT_MAX, 0, SAT_MIN, 1'b0));
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      n_errors++;
    end
  endtask

  // apb write, then read back the same register
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_ONE_SENSOR_MODE) ? {31'b0, value[0]} : value;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register readback", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROLL_COS_SIN:    active_cfg.roll_cos_sin = value;
      REG_PITCH_COS_SIN:   active_cfg.pitch_cos_sin = value;
      REG_YAW_COS_SIN:     active_cfg.yaw_cos_sin = value;
      REG_SHIFT_X:         active_cfg.shift_x = value;
      REG_SHIFT_Y:         active_cfg.shift_y = value;
      REG_SHIFT_Z:         active_cfg.shift_z = value;
      REG_ONE_SENSOR_MODE: active_cfg.one_sensor_mode = value[0];
      default: ;
    endcase
  endtask

  // hold until every request has been answered, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_pts.size() != 0 || in_valid_i || expected_pts.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // request driver: predict on acceptance, load the next point when free
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_pts = {expected_pts, predict_point(in_data_i, active_cfg)};
        n_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pts.size() != 0 &&
            ((n_sent >= 700 && n_sent < 1000) || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_pts.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          n_errors++;
        end else begin
          want_pt = expected_pts.pop_front();
          check_field("kept", 32'(want_pt.kept), 32'(out_data_o.kept));
          check_field("qx", want_pt.qx, out_data_o.qx);
          check_field("qy", want_pt.qy, out_data_o.qy);
          check_field("qz", want_pt.qz, out_data_o.qz);
          check_field("scan_end_out", 32'(want_pt.scan_end_out), 32'(out_data_o.scan_end_out));
        end
        n_recv++;
      end
      out_ready_i <= (n_recv >= 700 && n_recv < 1000) || $urandom_range(99) >= IDLE_PERCENT;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // reset, directed points, then phases of register settings each followed by points
  initial begin
    active_cfg = '{TRIG_IDENTITY, TRIG_IDENTITY, TRIG_IDENTITY, 32'sd0, 32'sd0, 32'sd0, 1'b0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    push_directed();
    wait_drained();
    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      case (ph)
        1: next_cfg = '{TRIG_IDENTITY, TRIG_IDENTITY, TRIG_IDENTITY,
                        32'sd0, 32'sd0, 32'sd0, 1'b1};
        3: next_cfg = '{32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1};
        4: next_cfg = '{32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0};
        5, 8: next_cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           1'($urandom_range(1))};
        default: next_cfg = '{rand_cos_sin(), rand_cos_sin(), rand_cos_sin(),
                              rand_shift(), rand_shift(), rand_shift(), 1'(ph % 2)};
      endcase
      write_reg(REG_ROLL_COS_SIN, next_cfg.roll_cos_sin);
      write_reg(REG_PITCH_COS_SIN, next_cfg.pitch_cos_sin);
      write_reg(REG_YAW_COS_SIN, next_cfg.yaw_cos_sin);
      write_reg(REG_SHIFT_X, next_cfg.shift_x);
      write_reg(REG_SHIFT_Y, next_cfg.shift_y);
      write_reg(REG_SHIFT_Z, next_cfg.shift_z);
      write_reg(REG_ONE_SENSOR_MODE, {31'b0, next_cfg.one_sensor_mode});
      @(negedge clk_i);
      if (ph == 3) push_directed();
      repeat (ITEMS_PER_PHASE) queue_point(rand_point());
      wait_drained();
    end
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
